// ===== design/ric_pkg.sv =====
// Shared types, constants and helper functions for ring_interp_coefficients.
// No dependencies; used by every module under design/.
package ric_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NUM_RING   = 8;
  localparam int NUM_COEF   = 5;
  localparam int DIR_W      = 3;
  localparam int MODE_W     = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // internal headroom for sums of a few values and their triples
  localparam int WIDE_W  = VALUE_BITS + 8;
  localparam int MAG_W   = VALUE_BITS;          // |difference| < 2^VALUE_BITS
  localparam int PROD_W  = 2 * MAG_W + 1;       // 2*a*b
  localparam int DIV_W   = MAG_W + 2;           // a+b plus one bit
  localparam int QUO_W   = MAG_W + 1;           // 2ab/(a+b) <= 2*min(a,b)

  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int FRONT_STAGES    = 3;
  localparam int MUL_STAGE       = FRONT_STAGES;
  localparam int DIV_LAST        = MUL_STAGE + DIV_STAGES;
  localparam int NUM_STAGES      = DIV_LAST + 2;
  localparam int OUT_STAGE       = NUM_STAGES - 1;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SPLINE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HERMITE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PCHIP     = 3'd4;

  localparam logic [PADDR_W-1:0] REG_INTERP_MODE = 3'd0;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic             neg;
    logic             zero;
  } hm_op_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             neg;
  } hm_res_t;

  typedef struct packed {
    logic [NUM_COEF-1:0][VALUE_BITS-1:0] coef;
    logic                                pchip;
    logic                                even;
  } side_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctl_t;

  localparam value_t VALUE_MAX = value_t'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam value_t VALUE_MIN = value_t'({1'b1, {(VALUE_BITS-1){1'b0}}});

  function automatic wide_t ext(input value_t v);
    return wide_t'(v);
  endfunction

  function automatic value_t sat_value(input wide_t x);
    if (x > ext(VALUE_MAX)) begin
      return VALUE_MAX;
    end else if (x < ext(VALUE_MIN)) begin
      return VALUE_MIN;
    end
    return x[VALUE_BITS-1:0];
  endfunction

  // divide by two, truncating toward zero
  function automatic wide_t half_tz(input wide_t a);
    wide_t s;
    s = a + (a[WIDE_W-1] ? wide_t'(1) : wide_t'(0));
    return s >>> 1;
  endfunction

  function automatic wide_t abs_w(input wide_t a);
    return a[WIDE_W-1] ? -a : a;
  endfunction

  // limited end slope from near difference d0 and far difference d1
  function automatic wide_t onesided(input wide_t d0, input wide_t d1);
    wide_t t3;
    wide_t m;
    t3 = d0 + d0 + d0;
    m  = half_tz(t3 - d1);
    if (m == '0 || d0 == '0 || m[WIDE_W-1] != d0[WIDE_W-1]) begin
      return '0;
    end
    if ((d1 == '0 || d1[WIDE_W-1] != d0[WIDE_W-1]) && abs_w(m) > abs_w(t3)) begin
      return t3;
    end
    return m;
  endfunction

  function automatic value_t sat_quo(input hm_res_t r);
    logic big;
    big = |r.quo[QUO_W-1:VALUE_BITS-1];
    if (big) begin
      return r.neg ? VALUE_MIN : VALUE_MAX;
    end
    return r.neg ? -value_t'(r.quo[VALUE_BITS-1:0]) : value_t'(r.quo[VALUE_BITS-1:0]);
  endfunction

endpackage

// ===== design/ring_interp_coefficients.sv =====
// Top level of ring_interp_coefficients: APB mode register, pipeline
// control, sideband delay line and output stage. Depends on ric_pkg,
// ric_front and ric_hmean.
//
// Takes eight Q16.16 ring values and a direction and returns five saturated
// Q16.16 coefficients per beat for the selected mode (linear, quadratic,
// spline, Hermite, PCHIP; codes 5-7 act as PCHIP). Fully pipelined: one beat
// per cycle while out_ready_i is high; the harmonic-mean divider, retiring
// two quotient bits per stage, sets the pipeline length. Bubbles collapse,
// so with a stage empty, input is taken while a result waits in the output
// register. Write interp_mode at address 0 only while no beat is in flight.
module ring_interp_coefficients (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ric_pkg::PADDR_W-1:0]     paddr,
  input  logic [ric_pkg::PDATA_W-1:0]     pwdata,
  output logic [ric_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_0_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_1_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_2_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_3_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_4_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_5_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_6_i,
  input  logic signed [ric_pkg::VALUE_BITS-1:0] ring_value_7_i,
  input  logic [ric_pkg::DIR_W-1:0]       direction_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ric_pkg::VALUE_BITS-1:0] coef_0_o,
  output logic signed [ric_pkg::VALUE_BITS-1:0] coef_1_o,
  output logic signed [ric_pkg::VALUE_BITS-1:0] coef_2_o,
  output logic signed [ric_pkg::VALUE_BITS-1:0] coef_3_o,
  output logic signed [ric_pkg::VALUE_BITS-1:0] coef_4_o
);

  localparam int NS = ric_pkg::NUM_STAGES;

  // config register
  logic [ric_pkg::MODE_W-1:0] mode_q;
  logic cfg_wr, cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[ric_pkg::PADDR_W-1] == ric_pkg::REG_INTERP_MODE[ric_pkg::PADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = cfg_hit ? ric_pkg::PDATA_W'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ric_pkg::MODE_PCHIP;
    end else if (cfg_wr && cfg_hit) begin
      mode_q <= pwdata[ric_pkg::MODE_W-1:0];
    end
  end

  // pipeline control: a stage loads when empty or when its contents move on
  logic [NS-1:0] vld_q, en;
  ric_pkg::pipe_ctl_t ctl;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld_q;
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  logic [ric_pkg::NUM_RING-1:0][ric_pkg::VALUE_BITS-1:0] ring;
  assign ring = {ring_value_7_i, ring_value_6_i, ring_value_5_i, ring_value_4_i,
                 ring_value_3_i, ring_value_2_i, ring_value_1_i, ring_value_0_i};

  ric_pkg::side_t  side_front;
  ric_pkg::hm_op_t hop_a, hop_b;
  ric_pkg::hm_res_t hres_a, hres_b;

  ric_front u_front (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .ring_i      (ring),
    .direction_i (direction_i),
    .mode_i      (mode_q),
    .side_o      (side_front),
    .hop_a_o     (hop_a),
    .hop_b_o     (hop_b)
  );

  ric_hmean u_hmean_a (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .op_i  (hop_a),
    .res_o (hres_a)
  );

  ric_hmean u_hmean_b (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .op_i  (hop_b),
    .res_o (hres_b)
  );

  // sideband follows the divider stages
  ric_pkg::side_t side_q [ric_pkg::MUL_STAGE:ric_pkg::DIV_LAST];

  always_ff @(posedge clk_i) begin
    if (en[ric_pkg::MUL_STAGE]) begin
      side_q[ric_pkg::MUL_STAGE] <= side_front;
    end
    for (int i = ric_pkg::MUL_STAGE + 1; i <= ric_pkg::DIV_LAST; i++) begin
      if (en[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // output stage: drop harmonic slopes into their slots
  ric_pkg::side_t out_d;
  logic [ric_pkg::NUM_COEF-1:0][ric_pkg::VALUE_BITS-1:0] coef_q;

  always_comb begin
    out_d = side_q[ric_pkg::DIV_LAST];
    if (out_d.pchip) begin
      if (out_d.even) begin
        out_d.coef[1] = ric_pkg::sat_quo(hres_a);
        out_d.coef[3] = ric_pkg::sat_quo(hres_b);
      end else begin
        out_d.coef[0] = ric_pkg::sat_quo(hres_a);
        out_d.coef[2] = ric_pkg::sat_quo(hres_b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ric_pkg::OUT_STAGE]) begin
      coef_q <= out_d.coef;
    end
  end

  assign out_valid_o = vld_q[ric_pkg::OUT_STAGE];
  assign coef_0_o    = coef_q[0];
  assign coef_1_o    = coef_q[1];
  assign coef_2_o    = coef_q[2];
  assign coef_3_o    = coef_q[3];
  assign coef_4_o    = coef_q[4];

`ifndef ASSERT_OFF
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &vld_q)
    else $error("input stalled while pipeline has a bubble");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && cfg_hit |=> mode_q == $past(pwdata[ric_pkg::MODE_W-1:0]))
    else $error("interp_mode write lost");
`endif

endmodule

// ===== design/ric_front.sv =====
// Front stages: neighbor select, differences, and every coefficient but
// the harmonic slopes. Depends on ric_pkg.
module ric_front (
  input  logic                                          clk_i,
  input  ric_pkg::pipe_ctl_t                            ctl_i,
  input  logic [ric_pkg::NUM_RING-1:0][ric_pkg::VALUE_BITS-1:0] ring_i,
  input  logic [ric_pkg::DIR_W-1:0]                     direction_i,
  input  logic [ric_pkg::MODE_W-1:0]                    mode_i,
  output ric_pkg::side_t                                side_o,
  output ric_pkg::hm_op_t                               hop_a_o,
  output ric_pkg::hm_op_t                               hop_b_o
);

  localparam logic [ric_pkg::DIR_W-1:0] OFS1 = 3'd1;
  localparam logic [ric_pkg::DIR_W-1:0] OFS2 = 3'd2;
  localparam logic [ric_pkg::DIR_W-1:0] OFS6 = 3'd6;
  localparam logic [ric_pkg::DIR_W-1:0] OFS7 = 3'd7;

  // stage 0: selected neighbors
  ric_pkg::value_t y0_q, y1_q, y2_q, y6_q, y7_q;
  logic [ric_pkg::MODE_W-1:0] mode0_q;
  logic even0_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      y0_q    <= ric_pkg::value_t'(ring_i[direction_i]);
      y1_q    <= ric_pkg::value_t'(ring_i[direction_i + OFS1]);
      y2_q    <= ric_pkg::value_t'(ring_i[direction_i + OFS2]);
      y6_q    <= ric_pkg::value_t'(ring_i[direction_i + OFS6]);
      y7_q    <= ric_pkg::value_t'(ring_i[direction_i + OFS7]);
      mode0_q <= mode_i;
      even0_q <= ~direction_i[0];
    end
  end

  // stage 1: widened values and slope differences
  ric_pkg::wide_t w0_q, w1_q, w2_q, w6_q, w7_q;
  ric_pkg::wide_t a0_q, a1_q, b0_q, b1_q;
  ric_pkg::wide_t a0_d, a1_d, b0_d, b1_d;
  ric_pkg::wide_t w0, w1, w2, w6, w7;
  logic [ric_pkg::MODE_W-1:0] mode1_q;
  logic even1_q;

  always_comb begin
    w0 = ric_pkg::ext(y0_q);
    w1 = ric_pkg::ext(y1_q);
    w2 = ric_pkg::ext(y2_q);
    w6 = ric_pkg::ext(y6_q);
    w7 = ric_pkg::ext(y7_q);
    if (even0_q) begin
      a0_d = w1 - w0;
      a1_d = w2 - w1;
      b0_d = w7 - w0;
      b1_d = w6 - w7;
    end else begin
      a0_d = w0 - w7;
      a1_d = w1 - w0;
      b0_d = w0 - w1;
      b1_d = w7 - w0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      w0_q    <= w0;
      w1_q    <= w1;
      w2_q    <= w2;
      w6_q    <= w6;
      w7_q    <= w7;
      a0_q    <= a0_d;
      a1_q    <= a1_d;
      b0_q    <= b0_d;
      b1_q    <= b1_d;
      mode1_q <= mode0_q;
      even1_q <= even0_q;
    end
  end

  // stage 2: coefficients and harmonic operands
  ric_pkg::wide_t c [ric_pkg::NUM_COEF];
  ric_pkg::side_t side_d, side_q;
  ric_pkg::hm_op_t hop_a_d, hop_b_d, hop_a_q, hop_b_q;
  logic is_pchip;

  always_comb begin
    for (int i = 0; i < ric_pkg::NUM_COEF; i++) begin
      c[i] = '0;
    end
    is_pchip = 1'b0;
    case (mode1_q)
      ric_pkg::MODE_LINEAR: begin
      end
      ric_pkg::MODE_QUADRATIC: begin
        c[0] = w0_q;
        if (even1_q) begin
          c[2] = ric_pkg::half_tz(w2_q + w0_q - (w1_q + w1_q));
          c[1] = (w1_q - w0_q) - c[2];
          c[4] = ric_pkg::half_tz(w6_q + w0_q - (w7_q + w7_q));
          c[3] = (w7_q - w0_q) - c[4];
        end else begin
          c[2] = ric_pkg::half_tz(w1_q + w7_q - (w0_q + w0_q));
          c[4] = c[2];
          c[1] = (w0_q - w7_q) + c[2];
          c[3] = (w0_q - w1_q) + c[2];
        end
      end
      ric_pkg::MODE_SPLINE: begin
        if (even1_q) begin
          c[1] = ric_pkg::half_tz(3 * (w0_q - (w1_q + w1_q) + w2_q));
          c[3] = ric_pkg::half_tz(3 * (w0_q - (w7_q + w7_q) + w6_q));
        end else begin
          c[0] = ric_pkg::half_tz(3 * (w7_q - (w0_q + w0_q) + w1_q));
          c[2] = c[0];
        end
      end
      ric_pkg::MODE_HERMITE: begin
        if (even1_q) begin
          c[0] = w1_q - w0_q;
          c[1] = ric_pkg::half_tz(w2_q - w0_q);
          c[2] = w7_q - w0_q;
          c[3] = ric_pkg::half_tz(w6_q - w0_q);
        end else begin
          c[0] = ric_pkg::half_tz(w1_q - w7_q);
          c[1] = w1_q - w0_q;
          c[2] = -c[0];
          c[3] = w7_q - w0_q;
        end
      end
      default: begin
        is_pchip = 1'b1;
        if (even1_q) begin
          c[0] = ric_pkg::onesided(a0_q, a1_q);
          c[2] = ric_pkg::onesided(b0_q, b1_q);
        end else begin
          c[1] = ric_pkg::onesided(a1_q, a0_q);
          c[3] = ric_pkg::onesided(b1_q, b0_q);
        end
      end
    endcase
    for (int i = 0; i < ric_pkg::NUM_COEF; i++) begin
      side_d.coef[i] = ric_pkg::sat_value(c[i]);
    end
    side_d.pchip = is_pchip;
    side_d.even  = even1_q;

    hop_a_d.mag_a = ric_pkg::MAG_W'(ric_pkg::abs_w(a0_q));
    hop_a_d.mag_b = ric_pkg::MAG_W'(ric_pkg::abs_w(a1_q));
    hop_a_d.neg   = a0_q[ric_pkg::WIDE_W-1];
    hop_a_d.zero  = a0_q == '0 || a1_q == '0 ||
                    a0_q[ric_pkg::WIDE_W-1] != a1_q[ric_pkg::WIDE_W-1] || !is_pchip;
    hop_b_d.mag_a = ric_pkg::MAG_W'(ric_pkg::abs_w(b0_q));
    hop_b_d.mag_b = ric_pkg::MAG_W'(ric_pkg::abs_w(b1_q));
    hop_b_d.neg   = b0_q[ric_pkg::WIDE_W-1];
    hop_b_d.zero  = b0_q == '0 || b1_q == '0 ||
                    b0_q[ric_pkg::WIDE_W-1] != b1_q[ric_pkg::WIDE_W-1] || !is_pchip;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      side_q  <= side_d;
      hop_a_q <= hop_a_d;
      hop_b_q <= hop_b_d;
    end
  end

  assign side_o  = side_q;
  assign hop_a_o = hop_a_q;
  assign hop_b_o = hop_b_q;

endmodule

// ===== design/ric_hmean.sv =====
// Pipelined harmonic mean 2ab/(a+b): one multiply stage, then a restoring
// divider retiring two quotient bits per stage. Depends on ric_pkg.
module ric_hmean (
  input  logic               clk_i,
  input  ric_pkg::pipe_ctl_t ctl_i,
  input  ric_pkg::hm_op_t    op_i,
  output ric_pkg::hm_res_t   res_o
);

  localparam int DS = ric_pkg::DIV_STAGES;
  localparam int QW = ric_pkg::QUO_W;
  localparam int DW = ric_pkg::DIV_W;
  localparam int SP = ric_pkg::STEPS_PER_STAGE;
  localparam int PW = 2 * ric_pkg::MAG_W;

  logic [ric_pkg::PROD_W-1:0] num_q;
  logic [DW-1:0]              den_q;
  logic                       neg_m_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ric_pkg::MUL_STAGE]) begin
      if (op_i.zero) begin
        num_q <= '0;
        den_q <= DW'(1);
      end else begin
        num_q <= {PW'(op_i.mag_a) * PW'(op_i.mag_b), 1'b0};
        den_q <= DW'(op_i.mag_a) + DW'(op_i.mag_b);
      end
      neg_m_q <= op_i.neg;
    end
  end

  logic [DW-1:0] rem_q [DS];
  logic [QW-1:0] nq_q  [DS];
  logic [DW-1:0] den_s_q [DS];
  logic          neg_s_q [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DW-1:0] rem_in, rem_d, den_in;
    logic [QW-1:0] nq_in, nq_d;
    logic          neg_in;
    logic [DW:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      // quotient fits QW bits, so the top part is already below the divisor
      assign rem_in = DW'(num_q[ric_pkg::PROD_W-1:QW]);
      assign nq_in  = num_q[QW-1:0];
      assign den_in = den_q;
      assign neg_in = neg_m_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign nq_in  = nq_q[j-1];
      assign den_in = den_s_q[j-1];
      assign neg_in = neg_s_q[j-1];
    end

    always_comb begin
      rem_d = rem_in;
      nq_d  = nq_in;
      trial = '0;
      ge    = 1'b0;
      for (int s = 0; s < SP; s++) begin
        if (j * SP + s < QW) begin
          trial = {rem_d, nq_d[QW-1]};
          ge    = trial >= {1'b0, den_in};
          if (ge) begin
            trial = trial - {1'b0, den_in};
          end
          rem_d = trial[DW-1:0];
          nq_d  = {nq_d[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en[ric_pkg::MUL_STAGE+1+j]) begin
        rem_q[j]   <= rem_d;
        nq_q[j]    <= nq_d;
        den_s_q[j] <= den_in;
        neg_s_q[j] <= neg_in;
      end
    end
  end

  assign res_o.quo = nq_q[DS-1];
  assign res_o.neg = neg_s_q[DS-1];

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk_i)
    ctl_i.vld[ric_pkg::DIV_LAST] |-> rem_q[DS-1] < den_s_q[DS-1])
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for ring_interp_coefficients: random and directed ring beats
// through valid/ready, APB mode writes between phases, scoreboard against local predictor.
// Depends on ric_pkg and the design top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ric_pkg::NUM_RING-1:0][ric_pkg::VALUE_BITS-1:0] vals;
    logic [ric_pkg::DIR_W-1:0]                             dir;
  } ring_beat_t;

  typedef logic [ric_pkg::NUM_COEF-1:0][ric_pkg::VALUE_BITS-1:0] coef_set_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ric_pkg::PADDR_W-1:0] paddr = '0;
  logic [ric_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ric_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [ric_pkg::VALUE_BITS-1:0] rv [ric_pkg::NUM_RING];
  logic [ric_pkg::DIR_W-1:0] direction_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [ric_pkg::VALUE_BITS-1:0] coef_0_o, coef_1_o, coef_2_o, coef_3_o, coef_4_o;

  ring_beat_t pending_beats[$];
  coef_set_t  expected_coefs[$];
  logic [ric_pkg::MODE_W-1:0] tb_mode = ric_pkg::MODE_PCHIP;
  logic in_taken = 1'b0;
  logic no_idle = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  initial begin
    for (int k = 0; k < ric_pkg::NUM_RING; k++) rv[k] = '0;
  end

  ring_interp_coefficients DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .ring_value_0_i(rv[0]), .ring_value_1_i(rv[1]), .ring_value_2_i(rv[2]),
    .ring_value_3_i(rv[3]), .ring_value_4_i(rv[4]), .ring_value_5_i(rv[5]),
    .ring_value_6_i(rv[6]), .ring_value_7_i(rv[7]),
    .direction_i, .out_valid_o, .out_ready_i,
    .coef_0_o, .coef_1_o, .coef_2_o, .coef_3_o, .coef_4_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic int sgn(longint a);
    return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
  endfunction

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint half(longint a);
    return a / 2;
  endfunction

  function automatic ric_pkg::value_t clip(longint x);
    if (x > longint'(ric_pkg::VALUE_MAX)) return ric_pkg::VALUE_MAX;
    if (x < longint'(ric_pkg::VALUE_MIN)) return ric_pkg::VALUE_MIN;
    return ric_pkg::value_t'(x);
  endfunction

  function automatic longint end_slope(longint d0, longint d1);
    longint m;
    m = half(3 * d0 - d1);
    if (sgn(m) * sgn(d0) <= 0) return 0;
    if (sgn(d0) * sgn(d1) <= 0 && mag(m) > mag(3 * d0)) return 3 * d0;
    return m;
  endfunction

  function automatic longint hmean_slope(longint d0, longint d1);
    logic [127:0] p;
    logic [63:0] a, b;
    if (sgn(d0) * sgn(d1) <= 0) return 0;
    a = mag(d0);
    b = mag(d1);
    p = ({64'b0, a} * {64'b0, b}) << 1;
    p = p / {64'b0, a + b};
    return d0 > 0 ? longint'(p[63:0]) : -longint'(p[63:0]);
  endfunction

  function automatic coef_set_t predict_coefs(ring_beat_t bt,
                                              logic [ric_pkg::MODE_W-1:0] mode);
    longint y[ric_pkg::NUM_RING];
    longint c[ric_pkg::NUM_COEF];
    longint y0, y1, y2, y6, y7, a0, a1, b0, b1;
    logic even;
    coef_set_t r;
    for (int k = 0; k < ric_pkg::NUM_RING; k++)
      y[k] = longint'(ric_pkg::value_t'(bt.vals[k]));
    for (int k = 0; k < ric_pkg::NUM_COEF; k++) c[k] = 0;
    y0 = y[bt.dir];
    y1 = y[3'(bt.dir + 3'd1)];
    y2 = y[3'(bt.dir + 3'd2)];
    y6 = y[3'(bt.dir + 3'd6)];
    y7 = y[3'(bt.dir + 3'd7)];
    even = ~bt.dir[0];
    case (mode)
      ric_pkg::MODE_LINEAR: ;
      ric_pkg::MODE_QUADRATIC: begin
        c[0] = y0;
        if (even) begin
          c[2] = half(y2 + y0 - 2 * y1);
          c[1] = y1 - y0 - c[2];
          c[4] = half(y6 + y0 - 2 * y7);
          c[3] = y7 - y0 - c[4];
        end else begin
          c[2] = half(y1 + y7 - 2 * y0);
          c[4] = c[2];
          c[1] = y0 - y7 + c[2];
          c[3] = y0 - y1 + c[4];
        end
      end
      ric_pkg::MODE_SPLINE: begin
        if (even) begin
          c[1] = half(3 * (y0 - 2 * y1 + y2));
          c[3] = half(3 * (y0 - 2 * y7 + y6));
        end else begin
          c[0] = half(3 * (y7 - 2 * y0 + y1));
          c[2] = c[0];
        end
      end
      ric_pkg::MODE_HERMITE: begin
        if (even) begin
          c[0] = y1 - y0;
          c[1] = half(y2 - y0);
          c[2] = y7 - y0;
          c[3] = half(y6 - y0);
        end else begin
          c[0] = half(y1 - y7);
          c[1] = y1 - y0;
          c[2] = -c[0];
          c[3] = y7 - y0;
        end
      end
      default: begin
        if (even) begin
          a0 = y1 - y0; a1 = y2 - y1; b0 = y7 - y0; b1 = y6 - y7;
          c[0] = end_slope(a0, a1);
          c[1] = hmean_slope(a0, a1);
          c[2] = end_slope(b0, b1);
          c[3] = hmean_slope(b0, b1);
        end else begin
          a0 = y0 - y7; a1 = y1 - y0; b0 = y0 - y1; b1 = y7 - y0;
          c[0] = hmean_slope(a0, a1);
          c[1] = end_slope(a1, a0);
          c[2] = hmean_slope(b0, b1);
          c[3] = end_slope(b1, b0);
        end
      end
    endcase
    for (int k = 0; k < ric_pkg::NUM_COEF; k++) r[k] = clip(c[k]);
    return r;
  endfunction

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
          ring_beat_t bt;
          bt = pending_beats.pop_front();
          for (int k = 0; k < ric_pkg::NUM_RING; k++) rv[k] <= bt.vals[k];
          direction_i <= bt.dir;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    ring_beat_t bt;
    coef_set_t got, exp_c;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = rv[k];
        bt.dir = direction_i;
        expected_coefs.push_back(predict_coefs(bt, tb_mode));
      end
      if (out_valid_o && out_ready_i) begin
        got = {coef_4_o, coef_3_o, coef_2_o, coef_1_o, coef_0_o};
        if (expected_coefs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_c = expected_coefs.pop_front();
          for (int k = 0; k < ric_pkg::NUM_COEF; k++) begin
            if (got[k] !== exp_c[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("coef_%0d mismatch: expected %h actual %h", k, exp_c[k], got[k]);
            end
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic apb_write(logic [ric_pkg::PADDR_W-1:0] addr,
                           logic [ric_pkg::PDATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ric_pkg::REG_INTERP_MODE) tb_mode = data[ric_pkg::MODE_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || expected_coefs.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [ric_pkg::VALUE_BITS-1:0] rand_value(int kind);
    case (kind)
      0: return $urandom();
      1: return ric_pkg::VALUE_BITS'($signed($urandom_range(400)) - 200);
      2: return $urandom_range(1) ? ric_pkg::VALUE_MAX : ric_pkg::VALUE_MIN;
      default: return ric_pkg::VALUE_BITS'($signed($urandom_range(32'h0040_0000))
                                           - 32'sh0020_0000);
    endcase
  endfunction

  function automatic ring_beat_t rand_beat();
    ring_beat_t bt;
    int kind;
    longint base, step;
    kind = $urandom_range(5);
    bt.dir = 3'($urandom_range(7));
    if (kind >= 4) begin
      // monotone or curved ramps keep pchip slopes away from the sign-change cases
      base = longint'($signed(rand_value(3)));
      step = $urandom_range(1) ? longint'($urandom_range(65536))
                               : -longint'($urandom_range(65536));
      for (int k = 0; k < ric_pkg::NUM_RING; k++)
        bt.vals[3'(bt.dir + 3'(k))] = clip(base + step * (k < 4 ? k : k - 8)
                                          + (kind == 5 ? longint'(k * k * 37) : 0));
    end else begin
      for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = rand_value(kind);
    end
    return bt;
  endfunction

  task automatic add_directed();
    ring_beat_t bt;
    for (int d = 0; d < 8; d++) begin
      bt.dir = 3'(d);
      for (int k = 0; k < ric_pkg::NUM_RING; k++)
        bt.vals[k] = (k % 2 == 0) ? ric_pkg::VALUE_MAX : ric_pkg::VALUE_MIN;
      pending_beats.push_back(bt);
      for (int k = 0; k < ric_pkg::NUM_RING; k++)
        bt.vals[k] = ric_pkg::VALUE_BITS'(k * 65536);
      pending_beats.push_back(bt);
    end
    bt.dir = 3'd0;
    for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = '0;
    pending_beats.push_back(bt);
    for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = ric_pkg::VALUE_MAX;
    pending_beats.push_back(bt);
    for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = ric_pkg::VALUE_MIN;
    pending_beats.push_back(bt);
    bt.dir = 3'd1;
    for (int k = 0; k < ric_pkg::NUM_RING; k++)
      bt.vals[k] = (k < 4) ? ric_pkg::VALUE_MIN : ric_pkg::VALUE_MAX;
    pending_beats.push_back(bt);
    for (int k = 0; k < ric_pkg::NUM_RING; k++) bt.vals[k] = (k == 1) ? 32'sd5 : 32'sd0;
    pending_beats.push_back(bt);
  endtask

  initial begin
    logic [ric_pkg::MODE_W-1:0] modes [9];
    modes = '{ric_pkg::MODE_PCHIP, ric_pkg::MODE_LINEAR, ric_pkg::MODE_QUADRATIC,
              ric_pkg::MODE_SPLINE, ric_pkg::MODE_HERMITE,
              3'd5, 3'd6, 3'd7, ric_pkg::MODE_QUADRATIC};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    wait_idle();
    for (int ph = 0; ph < 9; ph++) begin
      apb_write(ric_pkg::REG_INTERP_MODE, ric_pkg::PDATA_W'(modes[ph]));
      // address 4 does not hit interp_mode; the write must leave the mode alone
      if (ph == 2) apb_write(3'd4, ric_pkg::PDATA_W'(ric_pkg::MODE_LINEAR));
      no_idle = (ph == 3);
      for (int n = 0; n < 180; n++) pending_beats.push_back(rand_beat());
      wait_idle();
    end
    no_idle = 1'b0;
    if (mismatches == 0 && expected_coefs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ric_pkg.sv
design/ric_front.sv
design/ric_hmean.sv
design/ring_interp_coefficients.sv
tb/tb_top.sv
